[hw/rtl/pnacc_pkg.sv]
package pnacc_pkg;

    // Action codes carried in the input tuser.
    localparam logic [1:0] ACT_ACC   = 2'd0;
    localparam logic [1:0] ACT_EVENT = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Fixed field widths and fixed-point formats.
    localparam int FRAC_BITS = 8;
    localparam int IN_SAMP_W = 14;
    localparam int HIT_W     = 24;
    localparam int EVENT_W   = 32;
    localparam int M2_W      = 58;
    localparam int MEAN_W    = 22;
    localparam int NOISE_W   = 21;

    // Shared divider and square root sizes.
    localparam int DIV_W   = 58;
    localparam int DEN_W   = 24;
    localparam int STEP_W  = 6;
    localparam int ROOTX_W = 64;
    localparam int ROOT_W  = 32;

    localparam logic [HIT_W-1:0]   HIT_MAX   = {HIT_W{1'b1}};
    localparam logic [EVENT_W-1:0] EVENT_MAX = {EVENT_W{1'b1}};
    localparam logic [M2_W-1:0]    M2_MAX    = {M2_W{1'b1}};
    localparam logic [DIV_W-1:0]   VAR_MAX   = {2'b00, {56{1'b1}}};
    localparam logic [ROOT_W-1:0]  NOISE_MAX = {11'd0, {NOISE_W{1'b1}}};

    // Divider command: start pulse and number of quotient bits to produce.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

endpackage

[hw/rtl/pnacc_div.sv]
// Restoring divider, one quotient bit per cycle, for the top `steps` bits.
module pnacc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pnacc_pkg::div_ctl_t            ctl,
    input  logic [pnacc_pkg::DIV_W-1:0]    dividend,
    input  logic [pnacc_pkg::DEN_W-1:0]    divisor,
    output logic [pnacc_pkg::DIV_W-1:0]    quotient,
    output logic                           done
);

    logic [pnacc_pkg::DIV_W-1:0]  dvd_reg;
    logic [pnacc_pkg::DIV_W-1:0]  quo_reg;
    logic [pnacc_pkg::DEN_W:0]    rem_reg;
    logic [pnacc_pkg::DEN_W-1:0]  den_reg;
    logic [pnacc_pkg::STEP_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [pnacc_pkg::DEN_W:0]    rem_sh;
    logic                         fits;

    // Bring in the next dividend bit and trial-subtract the divisor.
    always_comb
    begin
        rem_sh = {rem_reg[pnacc_pkg::DEN_W-1:0], dvd_reg[pnacc_pkg::DIV_W-1]};
        fits   = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                dvd_reg  <= dividend << (pnacc_pkg::STEP_W'(pnacc_pkg::DIV_W) - ctl.steps);
                den_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= ctl.steps;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                dvd_reg <= {dvd_reg[pnacc_pkg::DIV_W-2:0], 1'b0};
                rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
                quo_reg <= {quo_reg[pnacc_pkg::DIV_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pnacc_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[hw/rtl/pnacc_sqrt.sv]
// Floor square root of a 64-bit radicand, one root bit per cycle.
module pnacc_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pnacc_pkg::ROOTX_W-1:0]   x,
    output logic [pnacc_pkg::ROOT_W-1:0]    root,
    output logic                            done
);

    localparam int REM_W = pnacc_pkg::ROOT_W + 3;

    logic [pnacc_pkg::ROOTX_W-1:0] x_reg;
    logic [pnacc_pkg::ROOT_W-1:0]  root_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [5:0]                    cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [REM_W-1:0]              rem_sh;
    logic [REM_W-1:0]              trial;
    logic                          fits;

    // Bring in two radicand bits and test against 4*root + 1.
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], x_reg[pnacc_pkg::ROOTX_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                x_reg    <= x;
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= 6'(pnacc_pkg::ROOT_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                x_reg    <= {x_reg[pnacc_pkg::ROOTX_W-3:0], 2'b00};
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[pnacc_pkg::ROOT_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[hw/rtl/per_channel_pedestal_noise_accumulator_unit.sv]
// Accumulate: per used sample a divide, a multiply and an add, then the row write-back; end of event: counted in idle.
// Read: per sample a divide and a square root when the hit count is above one, then the output beat.
// Rate is set by the shared bit-serial divider and the bit-serial square root unit.
// One beat is taken at a time; the input is not ready until the previous one is done.
// After reset the channel table is cleared, one row per cycle.
// Reset is asynchronous, active low, and clears the state, counters, start pulses and output valid.
module per_channel_pedestal_noise_accumulator_unit #(
    parameter int CHANNELS    = 4096,
    parameter int SAMPLES     = 6,
    parameter int SAMPLE_BITS = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // channel[11:0], sample_count[14:12], sample_0..sample_5 14 bits each from bit 15
    input  logic [103:0] s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // mean_value[21:0], noise_value[42:22], hit_total[66:43], event_total[98:67]
    output logic [103:0] m_tdata,
    // sample_index[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int MB  = SAMPLE_BITS + pnacc_pkg::FRAC_BITS;
    localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SIW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int RW  = pnacc_pkg::HIT_W + SAMPLES * (MB + pnacc_pkg::M2_W);
    localparam int M2B = pnacc_pkg::HIT_W + SAMPLES * MB;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH, ST_LOAD,
        ST_ACC_STEP, ST_ACC_DWAIT, ST_ACC_MUL, ST_ACC_ADD, ST_WRITE,
        ST_RD_STEP, ST_RD_DWAIT, ST_RD_SWAIT, ST_OUT
    } state_t;

    state_t state_reg;

    // Channel table: hit count, means and M2 sums of one channel per row.
    logic [RW-1:0] mem [CHANNELS];
    logic [RW-1:0] row_rd_reg;
    logic [RW-1:0] row_pack;
    logic [RW-1:0] mem_wdata;
    logic [AW-1:0] mem_addr;
    logic          mem_we;

    logic [AW-1:0]                  clr_reg;
    logic [AW-1:0]                  ch_addr_reg;
    logic                           ch_ok_reg;
    logic [1:0]                     act_reg;
    logic [2:0]                     used_reg;
    logic [2:0]                     s_reg;
    logic [SAMPLE_BITS-1:0]         samp_reg [SAMPLES];
    logic [pnacc_pkg::HIT_W-1:0]    hit_reg;
    logic [MB-1:0]                  mean_reg [SAMPLES];
    logic [pnacc_pkg::M2_W-1:0]     m2_reg [SAMPLES];
    logic [pnacc_pkg::EVENT_W-1:0]  event_reg;
    logic                           dneg_reg;
    logic [MB-1:0]                  dmag_reg;
    logic [2*MB-1:0]                prod_reg;

    pnacc_pkg::div_ctl_t            div_ctl_reg;
    logic [pnacc_pkg::DIV_W-1:0]    div_dvd_reg;
    logic [pnacc_pkg::DIV_W-1:0]    div_quo;
    logic                           div_done;
    logic                           sqrt_start_reg;
    logic [pnacc_pkg::ROOTX_W-1:0]  sqrt_x_reg;
    logic [pnacc_pkg::ROOT_W-1:0]   sqrt_root;
    logic                           sqrt_done;

    logic                           out_valid_reg;
    logic [2:0]                     out_idx_reg;
    logic                           out_last_reg;
    logic [pnacc_pkg::MEAN_W-1:0]   out_mean_reg;
    logic [pnacc_pkg::NOISE_W-1:0]  out_noise_reg;
    logic [pnacc_pkg::HIT_W-1:0]    out_hit_reg;
    logic [pnacc_pkg::EVENT_W-1:0]  out_event_reg;

    logic [pnacc_pkg::IN_SAMP_W-1:0] in_samp [6];
    logic [MB-1:0]                   row_mean [SAMPLES];
    logic [pnacc_pkg::M2_W-1:0]      row_m2 [SAMPLES];
    logic [SIW-1:0]                  sidx;
    logic [MB-1:0]                   cur_v;
    logic [MB-1:0]                   cur_mean;
    logic [MB:0]                     cur_delta;
    logic [MB-1:0]                   dmag;
    logic [MB-1:0]                   mean_new;
    logic [pnacc_pkg::M2_W:0]        m2_sum;
    logic [pnacc_pkg::DIV_W-1:0]     var_lim;
    logic [pnacc_pkg::ROOT_W-1:0]    noise_lim;
    logic                            in_ok;

    pnacc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl_reg),
        .dividend (div_dvd_reg),
        .divisor  (hit_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    pnacc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start_reg),
        .x     (sqrt_x_reg),
        .root  (sqrt_root),
        .done  (sqrt_done)
    );

    // Unpack the input beat and the fetched row; pack the working row.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            in_samp[i] = s_tdata[15 + i*pnacc_pkg::IN_SAMP_W +: pnacc_pkg::IN_SAMP_W];
        end
        row_pack[pnacc_pkg::HIT_W-1:0] = hit_reg;
        for (int i = 0; i < SAMPLES; i++)
        begin
            row_mean[i] = row_rd_reg[pnacc_pkg::HIT_W + i*MB +: MB];
            row_m2[i]   = row_rd_reg[M2B + i*pnacc_pkg::M2_W +: pnacc_pkg::M2_W];
            row_pack[pnacc_pkg::HIT_W + i*MB +: MB] = mean_reg[i];
            row_pack[M2B + i*pnacc_pkg::M2_W +: pnacc_pkg::M2_W] = m2_reg[i];
        end
        in_ok = 32'(s_tdata[11:0]) < CHANNELS;
    end

    // Datapath around the current sample position.
    always_comb
    begin
        sidx      = s_reg[SIW-1:0];
        cur_v     = {samp_reg[sidx], {pnacc_pkg::FRAC_BITS{1'b0}}};
        cur_mean  = mean_reg[sidx];
        cur_delta = {1'b0, cur_v} - {1'b0, cur_mean};
        dmag      = cur_delta[MB] ? MB'(-cur_delta) : cur_delta[MB-1:0];
        mean_new  = dneg_reg ? cur_mean - div_quo[MB-1:0] : cur_mean + div_quo[MB-1:0];
        m2_sum    = {1'b0, m2_reg[sidx]}
                  + (pnacc_pkg::M2_W+1)'(prod_reg >> pnacc_pkg::FRAC_BITS);
        var_lim   = (div_quo > pnacc_pkg::VAR_MAX) ? pnacc_pkg::VAR_MAX : div_quo;
        noise_lim = (sqrt_root > pnacc_pkg::NOISE_MAX) ? pnacc_pkg::NOISE_MAX : sqrt_root;
    end

    // Table port: clear sweep after reset, write-back after an accumulate.
    always_comb
    begin
        mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
        mem_addr  = (state_reg == ST_CLEAR) ? clr_reg : ch_addr_reg;
        mem_wdata = (state_reg == ST_CLEAR) ? '0 : row_pack;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        row_rd_reg <= mem[mem_addr];
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            event_reg      <= '0;
            s_reg          <= '0;
            div_ctl_reg    <= '0;
            sqrt_start_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            div_ctl_reg.start <= 1'b0;
            sqrt_start_reg    <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(CHANNELS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        act_reg     <= s_tuser;
                        ch_addr_reg <= AW'(s_tdata[11:0]);
                        ch_ok_reg   <= in_ok;
                        used_reg    <= (s_tdata[14:12] > 3'(SAMPLES)) ? 3'(SAMPLES)
                                                                      : s_tdata[14:12];
                        for (int i = 0; i < SAMPLES; i++)
                        begin
                            samp_reg[i] <= SAMPLE_BITS'(in_samp[i]);
                        end
                        unique case (s_tuser)
                            pnacc_pkg::ACT_ACC:
                            begin
                                if (in_ok)
                                begin
                                    state_reg <= ST_FETCH;
                                end
                            end
                            pnacc_pkg::ACT_EVENT:
                            begin
                                if (event_reg != pnacc_pkg::EVENT_MAX)
                                begin
                                    event_reg <= event_reg + 1'b1;
                                end
                            end
                            pnacc_pkg::ACT_READ:
                            begin
                                state_reg <= ST_FETCH;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_FETCH:
                begin
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    s_reg <= '0;
                    for (int i = 0; i < SAMPLES; i++)
                    begin
                        mean_reg[i] <= ch_ok_reg ? row_mean[i] : '0;
                        m2_reg[i]   <= ch_ok_reg ? row_m2[i] : '0;
                    end
                    if (act_reg == pnacc_pkg::ACT_ACC)
                    begin
                        hit_reg <= (row_rd_reg[pnacc_pkg::HIT_W-1:0] == pnacc_pkg::HIT_MAX)
                                 ? pnacc_pkg::HIT_MAX
                                 : row_rd_reg[pnacc_pkg::HIT_W-1:0] + 1'b1;
                        state_reg <= ST_ACC_STEP;
                    end
                    else
                    begin
                        hit_reg   <= ch_ok_reg ? row_rd_reg[pnacc_pkg::HIT_W-1:0] : '0;
                        state_reg <= ST_RD_STEP;
                    end
                end
                // Accumulate: mean += delta / n, then M2 += delta * (v - mean).
                ST_ACC_STEP:
                begin
                    if (s_reg >= used_reg)
                    begin
                        state_reg <= ST_WRITE;
                    end
                    else
                    begin
                        dneg_reg          <= cur_delta[MB];
                        dmag_reg          <= dmag;
                        div_dvd_reg       <= pnacc_pkg::DIV_W'(dmag);
                        div_ctl_reg.start <= 1'b1;
                        div_ctl_reg.steps <= pnacc_pkg::STEP_W'(MB);
                        state_reg         <= ST_ACC_DWAIT;
                    end
                end
                ST_ACC_DWAIT:
                begin
                    if (div_done)
                    begin
                        mean_reg[sidx] <= mean_new;
                        state_reg      <= ST_ACC_MUL;
                    end
                end
                ST_ACC_MUL:
                begin
                    prod_reg  <= dmag_reg * dmag;
                    state_reg <= ST_ACC_ADD;
                end
                ST_ACC_ADD:
                begin
                    m2_reg[sidx] <= m2_sum[pnacc_pkg::M2_W] ? pnacc_pkg::M2_MAX
                                                            : m2_sum[pnacc_pkg::M2_W-1:0];
                    s_reg     <= s_reg + 1'b1;
                    state_reg <= ST_ACC_STEP;
                end
                ST_WRITE:
                begin
                    state_reg <= ST_IDLE;
                end
                // Read: noise = sqrt((M2 / n) << 8) when n is above one.
                ST_RD_STEP:
                begin
                    out_idx_reg   <= s_reg;
                    out_last_reg  <= s_reg == 3'(SAMPLES - 1);
                    out_mean_reg  <= pnacc_pkg::MEAN_W'(cur_mean);
                    out_hit_reg   <= hit_reg;
                    out_event_reg <= event_reg;
                    if (hit_reg > pnacc_pkg::HIT_W'(1))
                    begin
                        div_dvd_reg       <= m2_reg[sidx];
                        div_ctl_reg.start <= 1'b1;
                        div_ctl_reg.steps <= pnacc_pkg::STEP_W'(pnacc_pkg::DIV_W);
                        state_reg         <= ST_RD_DWAIT;
                    end
                    else
                    begin
                        out_noise_reg <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_RD_DWAIT:
                begin
                    if (div_done)
                    begin
                        sqrt_x_reg     <= {var_lim[55:0], {pnacc_pkg::FRAC_BITS{1'b0}}};
                        sqrt_start_reg <= 1'b1;
                        state_reg      <= ST_RD_SWAIT;
                    end
                end
                ST_RD_SWAIT:
                begin
                    if (sqrt_done)
                    begin
                        out_noise_reg <= noise_lim[pnacc_pkg::NOISE_W-1:0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        s_reg         <= s_reg + 1'b1;
                        state_reg     <= out_last_reg ? ST_IDLE : ST_RD_STEP;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_event_reg, out_hit_reg, out_noise_reg, out_mean_reg};
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = out_last_reg;

endmodule

[tb/tb_per_channel_pedestal_noise_accumulator_unit.sv]
module tb_per_channel_pedestal_noise_accumulator_unit;

    localparam int NCH      = 4096;
    localparam int NSMP     = 6;
    localparam int SBITS    = 14;
    localparam int RAND_ITEMS = 330;

    // The only action code the block does not know.
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    per_channel_pedestal_noise_accumulator_unit #(
        .CHANNELS(NCH),
        .SAMPLES(NSMP),
        .SAMPLE_BITS(SBITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // One result beat of a channel read.
    typedef struct {
        logic [2:0]  idx;
        logic [21:0] mean;
        logic [20:0] noise;
        logic [23:0] hits;
        logic [31:0] events;
        logic        last;
    } stat_beat_t;

    // One row of the directed stimulus; a typed row carries its read answer.
    typedef struct {
        logic [1:0]  act;
        logic [11:0] ch;
        logic [2:0]  cnt;
        logic [83:0] smp;
        logic        typed;
        logic [21:0] t_mean;
        logic [20:0] t_noise;
        logic [23:0] t_hits;
        logic [31:0] t_events;
    } stim_row_t;

    localparam int NROWS = 19;
    stim_row_t rows [NROWS] = '{
        '{pnacc_pkg::ACT_READ, 12'd0, 3'd0, 84'd0, 1'b1, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_READ, 12'd4095, 3'd0, 84'd0, 1'b1, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_EVENT, 12'd0, 3'd0, 84'd0, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_ACC, 12'd5, 3'd6, {6{14'h3FFF}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_READ, 12'd5, 3'd0, 84'd0, 1'b1, 22'd4194048, 21'd0, 24'd1, 32'd1},
        '{pnacc_pkg::ACT_ACC, 12'd5, 3'd6, 84'd0, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_READ, 12'd5, 3'd0, 84'd0, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_ACC, 12'd4095, 3'd0, {6{14'h3FFF}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_READ, 12'd4095, 3'd0, 84'd0, 1'b1, 22'd0, 21'd0, 24'd1, 32'd1},
        '{pnacc_pkg::ACT_ACC, 12'd7, 3'd7, {6{14'h2AAA}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_ACC, 12'd7, 3'd7, {6{14'h1555}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_ACC, 12'd7, 3'd3, {6{14'h3FFF}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_READ, 12'd7, 3'd0, 84'd0, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{ACT_NONE, 12'd7, 3'd6, {6{14'h3FFF}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_EVENT, 12'd0, 3'd0, 84'd0, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_ACC, 12'd1, 3'd1, {6{14'd100}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_ACC, 12'd1, 3'd2, {6{14'd101}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_ACC, 12'd1, 3'd6, {6{14'h3FFF}}, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0},
        '{pnacc_pkg::ACT_READ, 12'd1, 3'd0, 84'd0, 1'b0, 22'd0, 21'd0, 24'd0, 32'd0}
    };

    // Shadow copy of the channel table.
    logic [23:0]       shadow_hits [NCH];
    longint            shadow_mean [NCH*NSMP];
    longint unsigned   shadow_m2   [NCH*NSMP];
    logic [31:0]       shadow_events;

    stat_beat_t pending_stats [$];
    int         errors;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_left;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #50000000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Integer square root, rounded down, one result bit per pass.
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    // Fold one hit into the shadow table (Welford update on Q.8 values).
    task automatic fold_hit(input logic [11:0] ch, input logic [2:0] cnt,
                            input logic [83:0] smp);
        longint n;
        int used;
        int k;
        longint v;
        longint m;
        longint delta;
        longint prod;
        longint unsigned add;
        if (shadow_hits[ch] != pnacc_pkg::HIT_MAX)
            shadow_hits[ch]++;
        n = shadow_hits[ch];
        used = (cnt > NSMP) ? NSMP : cnt;
        for (int s = 0; s < used; s++)
        begin
            k = ch * NSMP + s;
            v = longint'(smp[s*14 +: 14]) << pnacc_pkg::FRAC_BITS;
            m = shadow_mean[k];
            delta = v - m;
            m = m + delta / n;
            shadow_mean[k] = m;
            prod = delta * (v - m);
            add = (prod > 0) ? ($unsigned(prod) >> pnacc_pkg::FRAC_BITS) : 0;
            if (add > 64'(pnacc_pkg::M2_MAX) - shadow_m2[k])
                shadow_m2[k] = 64'(pnacc_pkg::M2_MAX);
            else
                shadow_m2[k] = shadow_m2[k] + add;
        end
    endtask

    // Expected statistics beats for a channel read.
    task automatic expect_read(input logic [11:0] ch);
        stat_beat_t b;
        longint unsigned n;
        longint unsigned var_q;
        longint unsigned root;
        n = shadow_hits[ch];
        for (int s = 0; s < NSMP; s++)
        begin
            b.idx = 3'(s);
            b.mean = shadow_mean[ch*NSMP + s][21:0];
            b.noise = '0;
            if (n > 1)
            begin
                var_q = shadow_m2[ch*NSMP + s] / n;
                if (var_q > 64'(pnacc_pkg::VAR_MAX))
                    var_q = 64'(pnacc_pkg::VAR_MAX);
                root = floor_root(var_q << pnacc_pkg::FRAC_BITS);
                b.noise = (root > 64'h1FFFFF) ? 21'h1FFFFF : root[20:0];
            end
            b.hits = n[23:0];
            b.events = shadow_events;
            b.last = (s == NSMP - 1);
            pending_stats.push_back(b);
        end
    endtask

    // Work out what one accepted beat causes.
    task automatic predict_beat(input logic [1:0] act, input logic [11:0] ch,
                                input logic [2:0] cnt, input logic [83:0] smp);
        case (act)
            pnacc_pkg::ACT_ACC:   fold_hit(ch, cnt, smp);
            pnacc_pkg::ACT_EVENT: if (shadow_events != pnacc_pkg::EVENT_MAX) shadow_events++;
            pnacc_pkg::ACT_READ:  expect_read(ch);
            default:   ;
        endcase
    endtask

    // Offer one beat, with random idle cycles ahead of it, until it is taken.
    task automatic send_beat(input logic [1:0] act, input logic [11:0] ch,
                             input logic [2:0] cnt, input logic [83:0] smp);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(99) < send_idle_pct)
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tuser <= act;
                s_tdata <= {5'd0, smp, cnt, ch};
                break;
            end
        end
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Receiver side: random stalls, plus one long hold-off when requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        stat_beat_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_stats.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                e = pending_stats.pop_front();
                if (m_tuser !== e.idx)
                    report_mismatch($sformatf("sample_index %0d, want %0d", m_tuser, e.idx));
                if (m_tdata[21:0] !== e.mean)
                    report_mismatch($sformatf("mean %0d, want %0d", m_tdata[21:0], e.mean));
                if (m_tdata[42:22] !== e.noise)
                    report_mismatch($sformatf("noise %0d, want %0d", m_tdata[42:22], e.noise));
                if (m_tdata[66:43] !== e.hits)
                    report_mismatch($sformatf("hit_total %0d, want %0d", m_tdata[66:43], e.hits));
                if (m_tdata[98:67] !== e.events)
                    report_mismatch($sformatf("event_total %0d, want %0d",
                                              m_tdata[98:67], e.events));
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("last %0b, want %0b", m_tlast, e.last));
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        stat_beat_t b;
        logic [1:0]  act;
        logic [11:0] ch;
        logic [2:0]  cnt;
        logic [83:0] smp;
        logic [11:0] pool [6];
        logic [13:0] base [6];
        int pick;
        int waited;

        errors = 0;
        hold_left = 0;
        send_idle_pct = 37;
        recv_idle_pct = 64;
        shadow_events = '0;
        for (int i = 0; i < NCH; i++)
            shadow_hits[i] = '0;
        for (int i = 0; i < NCH*NSMP; i++)
        begin
            shadow_mean[i] = 0;
            shadow_m2[i] = 0;
        end
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = pnacc_pkg::ACT_ACC;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part.
        for (int r = 0; r < NROWS; r++)
        begin
            send_beat(rows[r].act, rows[r].ch, rows[r].cnt, rows[r].smp);
            if (rows[r].typed)
            begin
                for (int s = 0; s < NSMP; s++)
                begin
                    b.idx = 3'(s);
                    b.mean = rows[r].t_mean;
                    b.noise = rows[r].t_noise;
                    b.hits = rows[r].t_hits;
                    b.events = rows[r].t_events;
                    b.last = (s == NSMP - 1);
                    pending_stats.push_back(b);
                end
            end
            else
                predict_beat(rows[r].act, rows[r].ch, rows[r].cnt, rows[r].smp);
        end

        // A small pool of channels so that counts grow and the noise becomes meaningful.
        pool[0] = 12'd0;
        pool[1] = 12'd4095;
        for (int i = 2; i < 6; i++)
            pool[i] = 12'($urandom_range(NCH - 1));
        for (int i = 0; i < 6; i++)
            base[i] = 14'($urandom_range(16383));

        // Hold off the receiver for a long stretch; the block stalls on its pending result beat.
        hold_left = 400;

        // Random part in three idling phases.
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 37;
            end
            else if (i == 2 * RAND_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 65)
                act = pnacc_pkg::ACT_ACC;
            else if (pick < 75)
                act = pnacc_pkg::ACT_EVENT;
            else if (pick < 97)
                act = pnacc_pkg::ACT_READ;
            else
                act = ACT_NONE;
            pick = $urandom_range(5);
            ch = ($urandom_range(99) < 85) ? pool[pick] : 12'($urandom_range(NCH - 1));
            cnt = ($urandom_range(99) < 70) ? 3'd6 : 3'($urandom_range(7));
            for (int s = 0; s < NSMP; s++)
            begin
                if ($urandom_range(99) < 20)
                    smp[s*14 +: 14] = 14'($urandom_range(16383));
                else
                    smp[s*14 +: 14] = base[pick] + 14'($urandom_range(64)) - 14'd32;
            end
            send_beat(act, ch, cnt, smp);
            predict_beat(act, ch, cnt, smp);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then wait before the final check.
        waited = 0;
        while (pending_stats.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (800) @(posedge clk);
        if (pending_stats.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", pending_stats.size()));

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[per_channel_pedestal_noise_accumulator_unit.f]
hw/rtl/pnacc_pkg.sv
hw/rtl/pnacc_div.sv
hw/rtl/pnacc_sqrt.sv
hw/rtl/per_channel_pedestal_noise_accumulator_unit.sv
tb/tb_per_channel_pedestal_noise_accumulator_unit.sv
